// ===== sv/hfc_pkg.sv =====
package hfc_pkg;

    // Direction codes
    localparam logic CMD_TO_HEX = 1'b0;
    localparam logic CMD_TO_DBL = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    // Double format
    localparam logic [10:0] DBL_EXP_ONES = 11'h7FF;
    localparam int          DBL_FRAC_W   = 52;
    localparam logic [10:0] DBL_BIAS     = 11'd1023;

    // Hex real format
    localparam int          HEX_FRAC_W   = 56;
    localparam logic [6:0]  HEX_BIAS     = 7'd64;

    // Hex exponent is q - 191, where q = (e + 1 - shift) / 4 and
    // 191 = (1023 + 1 - 4) / 4 - 64; it fits in 7 bits for q in 191..318
    localparam logic [9:0]  HEX_Q_LO     = 10'd191;
    localparam logic [9:0]  HEX_Q_HI     = 10'd318;

    // Double exponent from hex: 4*e + lead + (1023 - 256 - 4 - 52)
    localparam logic [10:0] DBL_EXP_OFS  = 11'd711;

    typedef struct packed {
        logic        cmd;
        logic [63:0] value_in;
    } req_t;

    typedef struct packed {
        logic [63:0] value_out;
        logic [1:0]  status;
    } rsp_t;

    // Stage 2 contents: finished hex result plus prepared hex-to-double data
    typedef struct packed {
        logic        cmd;
        logic [63:0] hex_word;
        logic [1:0]  hex_status;
        logic        sign;
        logic        frac_zero;
        logic [6:0]  hex_exp;
        logic [55:0] mant;
        logic [5:0]  lead;
    } mid_t;

endpackage

// ===== sv/hfc_lead_one.sv =====
module hfc_lead_one
    import hfc_pkg::*;
(
    input  logic [55:0] mant,
    output logic [5:0]  lead
);

    logic [6:0]      grp_any;
    logic [6:0][2:0] grp_pos;
    logic [2:0]      top_grp;

    // Find the highest set bit inside each byte
    always_comb
    begin
        for (int g = 0; g < 7; g++)
        begin
            grp_any[g] = |mant[g*8 +: 8];
            grp_pos[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (mant[g*8 + b])
                begin
                    grp_pos[g] = 3'(b);
                end
            end
        end
    end

    // Pick the highest byte that holds a one
    always_comb
    begin
        top_grp = 3'd0;
        for (int g = 0; g < 7; g++)
        begin
            if (grp_any[g])
            begin
                top_grp = 3'(g);
            end
        end
    end

    assign lead = {top_grp, grp_pos[top_grp]};

endmodule

// ===== sv/ieee_double_ibm_hex_float_convert.sv =====
// Each accepted request moves through the stage registers below in order to its result on rsp_valid.
// Throughput: one request per cycle while rsp_stall is low; the three stage registers (input,
//   leading-one search, normalize shift) each hold one request and advance
//   whenever the next stage is empty or moving.
// Reset: rst_n clears all stage valid bits asynchronously; no payload is reset.
module ieee_double_ibm_hex_float_convert
    import hfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when it is empty or
    // when its content moves on in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic rsp_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready  = !rsp_valid_reg || !rsp_stall;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_stall = !s1_ready;
    assign rsp_valid = rsp_valid_reg;

    req_t s1_reg;
    mid_t s2_reg;
    mid_t s2_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                rsp_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers: hold while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (s1_ready && req_valid)
        begin
            s1_reg <= req_data;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: finish double-to-hex, find the leading one of the hex
    // fraction for hex-to-double.
    // ------------------------------------------------------------------
    logic [10:0] d_exp;
    logic [51:0] d_frac;
    logic [1:0]  d_shift;
    logic [55:0] d_mant;
    logic [11:0] d_qsum;
    logic [9:0]  d_q;
    logic [6:0]  d_hexp;
    logic [55:0] h_mant;
    logic [5:0]  h_lead;

    assign d_exp   = s1_reg.value_in[62:52];
    assign d_frac  = s1_reg.value_in[51:0];
    // Align so the binary exponent becomes a multiple of four
    assign d_shift = d_exp[1:0] + 2'd1;
    assign d_mant  = 56'({1'b1, d_frac}) << d_shift;
    assign d_qsum  = 12'(d_exp) + 12'd1 - 12'(d_shift);
    assign d_q     = d_qsum[11:2];
    assign d_hexp  = 7'(d_q - HEX_Q_LO);

    assign h_mant  = s1_reg.value_in[55:0];

    hfc_lead_one u_lead_one (
        .mant (h_mant),
        .lead (h_lead)
    );

    always_comb
    begin
        s2_next            = '0;
        s2_next.cmd        = s1_reg.cmd;
        s2_next.sign       = s1_reg.value_in[63];
        s2_next.frac_zero  = (h_mant == '0);
        s2_next.hex_exp    = s1_reg.value_in[62:56];
        s2_next.mant       = h_mant;
        s2_next.lead       = h_lead;
        s2_next.hex_word   = '0;
        s2_next.hex_status = ST_OK;
        if (s1_reg.value_in[62:0] == '0)
        begin
            // Signed zero: plain zero, no flag
            s2_next.hex_word   = '0;
            s2_next.hex_status = ST_OK;
        end
        else if (d_exp == DBL_EXP_ONES || d_exp == '0)
        begin
            // Drop infinity, NaN and denormals
            s2_next.hex_word   = '0;
            s2_next.hex_status = ST_UNSUP;
        end
        else
        begin
            s2_next.hex_word   = {s1_reg.value_in[63], d_hexp, d_mant};
            s2_next.hex_status = (d_q < HEX_Q_LO || d_q > HEX_Q_HI) ? ST_RANGE : ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: normalize the hex fraction onto the hidden bit (right by
    // up to 3, left by up to 52), truncate, and rebias the exponent.
    // ------------------------------------------------------------------
    logic [55:0] n_mant;
    logic [10:0] n_exp;

    always_comb
    begin
        if (s2_reg.lead >= 6'(DBL_FRAC_W))
        begin
            n_mant = s2_reg.mant >> (s2_reg.lead - 6'(DBL_FRAC_W));
        end
        else
        begin
            n_mant = s2_reg.mant << (6'(DBL_FRAC_W) - s2_reg.lead);
        end
    end

    assign n_exp = 11'({s2_reg.hex_exp, 2'b00}) + 11'(s2_reg.lead) + DBL_EXP_OFS;

    always_comb
    begin
        rsp_next.value_out = s2_reg.hex_word;
        rsp_next.status    = s2_reg.hex_status;
        if (s2_reg.cmd == CMD_TO_DBL)
        begin
            rsp_next.status = ST_OK;
            if (s2_reg.frac_zero)
            begin
                rsp_next.value_out = {s2_reg.sign, 63'd0};
            end
            else
            begin
                rsp_next.value_out = {s2_reg.sign, n_exp, n_mant[DBL_FRAC_W-1:0]};
            end
        end
    end

    assign rsp_data = rsp_reg;

`ifndef SYNTHESIS
    // Status code three is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.status != 2'd3)
    else $error("invalid status code on result");

    // Hex-to-double requests always finish with an OK status
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_ready && s2_reg.cmd == CMD_TO_DBL)
        |=> (rsp_valid_reg && rsp_reg.status == ST_OK))
    else $error("hex-to-double result flagged");

    // An accepted request always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> s1_valid_reg)
    else $error("accepted request lost at input stage");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench
    import hfc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Random requests after the directed table
    localparam int RANDOM_REQUESTS = 2000;
    // Generous upper bound on the whole run, in ns
    localparam int RUN_LIMIT_NS = 5_000_000;
    // Cycles to keep watching the response side once nothing is outstanding
    localparam int SETTLE_CYCLES = 8;
    // Bound on the final drain, in cycles
    localparam int DRAIN_LIMIT = 5000;

    // Double exponents at the edges of the 7-bit hex exponent range
    localparam logic [10:0] DBL_E_HEX_LOW  = 11'd763;   // hex exponent 0
    localparam logic [10:0] DBL_E_HEX_HIGH = 11'd1274;  // hex exponent 127

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // One line of the directed table; "typed" rows carry their own answer
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    rsp_t        pending_words[$];
    dir_row_t    directed_rows[$];
    int          errors = 0;
    int          cycle = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    rsp_t        oldest;

    ieee_double_ibm_hex_float_convert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    // Convert one word the way the block must: double to excess-64 hex real or back.
    function automatic rsp_t convert_word(input req_t r);
        rsp_t        o;
        logic        sgn;
        logic [10:0] be;
        logic [1:0]  sh;
        logic [55:0] frac;
        int          q;
        int          hexp;
        int          lead;
        int          dexp;
        o = '0;
        sgn = r.value_in[63];
        if (r.cmd == CMD_TO_HEX)
        begin
            be = r.value_in[62:52];
            if (r.value_in[62:0] == '0)
            begin
                o = '0;
            end
            else if (be == DBL_EXP_ONES || be == '0)
            begin
                o.status = ST_UNSUP;
            end
            else
            begin
                // align so the binary exponent becomes a multiple of four
                sh = 2'(be + 11'd1);
                frac = {3'b000, 1'b1, r.value_in[51:0]} << sh;
                q = (int'(be) + 1 - int'(sh)) / 4;
                hexp = q - ((int'(DBL_BIAS) + 1 - 4) / 4 - int'(HEX_BIAS));
                o.status = (hexp < 0 || hexp > 127) ? ST_RANGE : ST_OK;
                o.value_out = {sgn, 7'(hexp), frac};
            end
        end
        else
        begin
            frac = r.value_in[55:0];
            if (frac == '0)
            begin
                o.value_out = {sgn, 63'd0};
            end
            else
            begin
                lead = 0;
                for (int i = 0; i < 56; i++)
                    if (frac[i])
                        lead = i;
                // put the leading one on the hidden bit, either direction
                if (lead > DBL_FRAC_W)
                    frac = frac >> (lead - DBL_FRAC_W);
                else
                    frac = frac << (DBL_FRAC_W - lead);
                dexp = (int'(r.value_in[62:56]) - int'(HEX_BIAS)) * 4 - 4
                     + lead - DBL_FRAC_W + int'(DBL_BIAS);
                o.value_out = {sgn, 11'(dexp), frac[51:0]};
            end
        end
        return o;
    endfunction

    function automatic dir_row_t make_row(input logic cmd, input logic [63:0] word,
                                          input bit typed, input logic [63:0] out_word,
                                          input logic [1:0] status);
        dir_row_t d;
        d.req.cmd         = cmd;
        d.req.value_in    = word;
        d.typed           = typed;
        d.want.value_out  = out_word;
        d.want.status     = status;
        return d;
    endfunction

    // Draw a random request, weighted toward the interesting corners of each direction.
    function automatic req_t pick_request();
        req_t        r;
        logic [63:0] w;
        int          kind;
        r.cmd = 1'($urandom_range(0, 1));
        w = {$urandom, $urandom};
        kind = $urandom_range(0, 15);
        if (r.cmd == CMD_TO_HEX)
        begin
            case (kind)
                0: w[62:52] = DBL_EXP_ONES;                             // infinity or NaN
                1: w[62:52] = '0;                                       // denormal
                2: w[62:0] = '0;                                        // signed zero
                3, 4: w[62:52] = 11'(DBL_E_HEX_HIGH - 3 + $urandom_range(0, 7));
                5, 6: w[62:52] = 11'(DBL_E_HEX_LOW - 4 + $urandom_range(0, 7));
                7: w[51:0] = '0;                                        // exact powers of two
                8, 9, 10, 11: w[62:52] = 11'(DBL_E_HEX_LOW + $urandom_range(0, 511));
                default: ;                                              // raw word
            endcase
        end
        else
        begin
            case (kind)
                0: w[55:0] = '0;                                        // zero fraction
                1, 2, 3, 4: w[55:0] = w[55:0] >> $urandom_range(0, 55);
                5: w[55:0] = 56'd1 << $urandom_range(0, 55);
                default: ;
            endcase
        end
        r.value_in = w;
        return r;
    endfunction

    // Present one request and hold it until the block takes it. Stall is sampled
    // at the falling edge: inputs move only on rising edges, so it still holds
    // at the next rising edge, where the request is accepted.
    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        bit taken;
        taken = 1'b0;
        req_valid <= 1'b1;
        req_data  <= r;
        while (!taken)
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        pending_words.push_back(typed ? want : convert_word(r));
    endtask

    task automatic idle_cycles(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Response-side stall: switch between four patterns (none, light, heavy, periodic) at random intervals.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(50, 300);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= ((cycle % 7) < 3);
            default:        rsp_stall <= 1'b0;
        endcase
    end

    // Check each accepted result against the oldest outstanding expectation.
    // Sampled at the falling edge, where valid, stall and data already hold
    // the values seen at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid && !rsp_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: value_out %h status %0d",
                         $time, rsp_data.value_out, rsp_data.status);
                errors++;
            end
            else
            begin
                oldest = pending_words.pop_front();
                if (rsp_data.value_out !== oldest.value_out)
                begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, oldest.value_out, rsp_data.value_out);
                    errors++;
                end
                if (rsp_data.status !== oldest.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, rsp_data.status);
                    errors++;
                end
            end
        end
    end

    // Hard stop if the handshakes ever hang.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int   sent;
        int   burst;
        int   guard;
        bit   drained_mid;
        rsp_t none;

        req_valid = 1'b0;
        req_data  = '0;
        rst_n     = 1'b0;
        none      = '0;

        // Directed table: zeros, specials, exponent range edges, both directions
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h0000000000000000, 1'b1,
                                         64'h0000000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h8000000000000000, 1'b1,
                                         64'h0000000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h7FF0000000000000, 1'b1,
                                         64'h0000000000000000, ST_UNSUP));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'hFFF8000000000001, 1'b1,
                                         64'h0000000000000000, ST_UNSUP));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h0000000000000001, 1'b1,
                                         64'h0000000000000000, ST_UNSUP));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h800FFFFFFFFFFFFF, 1'b1,
                                         64'h0000000000000000, ST_UNSUP));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h3FF0000000000000, 1'b1,
                                         64'h4110000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'hC000000000000000, 1'b1,
                                         64'hC120000000000000, ST_OK));
        // first exponent past the top of the hex range wraps to zero
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h4FB0000000000000, 1'b1,
                                         64'h0010000000000000, ST_RANGE));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h0010000000000000, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h7FEFFFFFFFFFFFFF, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h4FAFFFFFFFFFFFFF, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'h2FB0000000000000, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'hAFA5555555555555, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_HEX, 64'hBFFAAAAAAAAAAAAA, 1'b0, '0, ST_OK));
        // hex words with a zero fraction give a signed zero double
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'hFF00000000000000, 1'b1,
                                         64'h8000000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h7F00000000000000, 1'b1,
                                         64'h0000000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h4110000000000000, 1'b1,
                                         64'h3FF0000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h4120000000000000, 1'b1,
                                         64'h4000000000000000, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'hFFFFFFFFFFFFFFFF, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h0000000000000001, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h7F80000000000000, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h00FFFFFFFFFFFFFF, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'hC100000000000001, 1'b0, '0, ST_OK));
        directed_rows.push_back(make_row(CMD_TO_DBL, 64'h4001000000000000, 1'b0, '0, ST_OK));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the table back to back: a stretch with no sender idling
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // Random requests in bursts; drain fully once halfway through
        sent = 0;
        drained_mid = 1'b0;
        while (sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++)
            begin
                send_request(pick_request(), 1'b0, none);
                sent++;
            end
            if (!drained_mid && sent >= RANDOM_REQUESTS / 2)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 6));
            end
        end

        // Let the pipeline empty, then watch a little longer for strays
        req_valid <= 1'b0;
        guard = 0;
        while (pending_words.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_words.size());
            errors++;
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
